@@ design/prs_pkg.sv @@
// Package for the pairwise rank sorter: entry type and field widths.
`timescale 1ns / 1ps
`default_nettype none
package prs_pkg;
	localparam int VAL_W = 9;
	localparam int POS_W = 6;

	typedef struct packed {
		logic             vld;
		logic [VAL_W-1:0] val;
	} prs_ent_t;

	typedef struct packed {
		logic ins;
		logic shift;
	} prs_ctl_t;
endpackage
`default_nettype wire

@@ design/prs_cell.sv @@
// One cell of the insertion chain: holds one entry, inserts or shifts.
`timescale 1ns / 1ps
`default_nettype none
module prs_cell
	import prs_pkg::*;
(
	input  wire              clk,
	input  wire              arst_n,
	input  prs_ctl_t         ctl,
	input  wire [VAL_W-1:0]  bval,
	input  prs_ent_t         prev_ent,
	input  wire              prev_keep,
	input  prs_ent_t         next_ent,
	output prs_ent_t         ent,
	output logic             keep
);
	logic             vld_q;
	logic [VAL_W-1:0] val_q;

	// entry holds its place when it is not greater than the new item
	assign keep = vld_q && (val_q <= bval);
	assign ent  = '{vld: vld_q, val: val_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctl.shift) begin
			vld_q <= next_ent.vld;
		end else if (ctl.ins && !keep) begin
			vld_q <= prev_keep ? 1'b1 : prev_ent.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			val_q <= next_ent.val;
		end else if (ctl.ins && !keep) begin
			val_q <= prev_keep ? bval : prev_ent.val;
		end
	end
endmodule
`default_nettype wire

@@ design/pairwise_rank_sorter_unit.sv @@
// Pairwise rank sorter: a chain of cells kept in stable ascending order.
// Usage:
//   Items enter on s_tvalid/s_tready/s_tdata (value) with s_tlast on the
//   final one of a set. Each item is inserted into a chain of
//   MAX_ITEMS cells, behind every held value not greater than it, so equal
//   values keep arrival order and a cell's place is the item's rank.
//   Items arriving while all cells are full are dropped; s_tlast still counts.
//   After the item with s_tlast, the set drains from cell 0 on
//   m_tvalid/m_tready/m_tdata (sorted value, rank) with m_tlast on the
//   final result. The first result is shown in the cycle after that item.
//   Load: one item per cycle. Drain: one result per cycle, N results for N
//   held values, paced by the chain shifting one cell per accepted result.
//   s_tready is low during the drain; a stalled receiver holds the chain
//   and the output still. Reset empties the chain and ends any drain.
`timescale 1ns / 1ps
`default_nettype none
module pairwise_rank_sorter_unit
	import prs_pkg::*;
#(
	parameter int MAX_ITEMS = 64
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire [15:0] s_tdata,  // [8:0] value, [15:9] zero
	input  wire        s_tlast,
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [15:0] m_tdata, // [8:0] sorted_value, [14:9] position, [15] zero
	output logic       m_tlast
);
	prs_ent_t   ent [MAX_ITEMS];
	logic       keep [MAX_ITEMS];
	prs_ctl_t   ctl;
	logic       drain_q;
	logic [POS_W-1:0] pos_q;
	logic       s_acc, m_acc, full;

	assign full     = ent[MAX_ITEMS-1].vld;
	assign s_tready = !drain_q;
	assign s_acc    = s_tvalid && s_tready;
	assign m_tvalid = drain_q && ent[0].vld;
	assign m_acc    = m_tvalid && m_tready;
	assign m_tlast  = !ent[1].vld;
	assign m_tdata  = {1'b0, pos_q, ent[0].val};
	assign ctl      = '{ins: s_acc && !full, shift: m_acc};

	genvar i;
	generate
		for (i = 0; i < MAX_ITEMS; i++) begin : g_cell
			prs_ent_t pe, ne;
			logic     pk;
			if (i == 0) begin : g_first
				assign pe = '0;
				assign pk = 1'b1;
			end else begin : g_mid
				assign pe = ent[i-1];
				assign pk = keep[i-1];
			end
			if (i == MAX_ITEMS - 1) begin : g_end
				assign ne = '0;
			end else begin : g_nxt
				assign ne = ent[i+1];
			end
			prs_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (ctl),
				.bval      (s_tdata[VAL_W-1:0]),
				.prev_ent  (pe),
				.prev_keep (pk),
				.next_ent  (ne),
				.ent       (ent[i]),
				.keep      (keep[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_q <= 1'b0;
			pos_q   <= '0;
		end else if (s_acc && s_tlast) begin
			drain_q <= 1'b1;
			pos_q   <= '0;
		end else if (m_acc) begin
			if (m_tlast) begin
				drain_q <= 1'b0;
				pos_q   <= '0;
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

@@ design/prs_checker.sv @@
// Port-level checker for the pairwise rank sorter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module prs_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire [15:0] s_tdata,
	input wire        s_tlast,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [15:0] m_tdata,
	input wire        m_tlast
);
	a_no_load_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("item accepted during drain");

	a_drain_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> (m_tvalid && m_tdata[14:9] == 6'd0))
		else $error("drain did not start at rank zero");

	a_drain_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> (!m_tvalid && s_tready))
		else $error("drain did not end after final item");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
		else $error("stalled result changed");
endmodule

bind pairwise_rank_sorter_unit prs_checker u_prs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
`default_nettype wire

@@ sim/testbench.sv @@
// Testbench for pairwise_rank_sorter_unit: directed and random sets checked against a stable rank predictor.
`timescale 1ns / 1ps
module testbench;
	import prs_pkg::*;

	localparam int SET_CAP = 64;
	localparam int RAND_ITEMS = 340;
	localparam int IDLE_PCT = 24;
	localparam int HOLD_CYCLES = 400;
	localparam int VAL_FULL = 0;
	localparam int VAL_NARROW = 1;
	localparam int VAL_EXTREME = 2;

	typedef struct packed {
		logic [VAL_W-1:0] val;
		logic [POS_W-1:0] pos;
		logic             fin;
	} sorted_ent_t;

	class rank_scoreboard;
		logic [VAL_W-1:0] set_vals[$];
		logic [POS_W-1:0] set_rank[$];
		sorted_ent_t      sorted_q[$];
		int               errors;
		int               items_in;
		int               results_out;

		function void note_item(logic [VAL_W-1:0] v, logic is_last);
			logic [POS_W-1:0] own;
			sorted_ent_t      run_out[];
			int               n;
			own = '0;
			items_in++;
			// an item arriving at a full set is dropped, but its last bit still counts
			if (set_vals.size() < SET_CAP) begin
				foreach (set_vals[k]) begin
					if (set_vals[k] > v)
						set_rank[k] = set_rank[k] + 1'b1;
					else
						own = own + 1'b1;
				end
				set_vals.push_back(v);
				set_rank.push_back(own);
			end
			if (is_last) begin
				n = set_vals.size();
				run_out = new[n];
				foreach (set_vals[k])
					run_out[set_rank[k]] = '{val: set_vals[k], pos: set_rank[k],
						fin: (int'(set_rank[k]) == n - 1)};
				foreach (run_out[r])
					sorted_q.push_back(run_out[r]);
				set_vals.delete();
				set_rank.delete();
			end
		endfunction

		function void check_result(logic [15:0] data, logic tl);
			sorted_ent_t got;
			sorted_ent_t want;
			got = '{val: data[VAL_W-1:0], pos: data[VAL_W+POS_W-1:VAL_W], fin: tl};
			results_out++;
			if (sorted_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected item: expected none, actual value %0d rank %0d last %0b",
					$time, got.val, got.pos, got.fin);
				return;
			end
			want = sorted_q.pop_front();
			if (got.val !== want.val) begin
				errors++;
				$display("%0t: sorted_value expected %0d actual %0d", $time, want.val, got.val);
			end
			if (got.pos !== want.pos) begin
				errors++;
				$display("%0t: position expected %0d actual %0d", $time, want.pos, got.pos);
			end
			if (got.fin !== want.fin) begin
				errors++;
				$display("%0t: m_tlast expected %0b actual %0b", $time, want.fin, got.fin);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic        m_tlast;

	rank_scoreboard sb = new;

	pairwise_rank_sorter_unit #(
		.MAX_ITEMS(SET_CAP)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #4 clk = ~clk;

	task automatic send_item(input logic [VAL_W-1:0] v, input logic is_last, input bit may_idle);
		s_tvalid <= 1'b1;
		s_tdata <= {{(16 - VAL_W){1'b0}}, v};
		s_tlast <= is_last;
		do @(posedge clk); while (!s_tready);
		sb.note_item(v, is_last);
		if (may_idle) begin
			while ($urandom_range(0, 99) < IDLE_PCT) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
	endtask

	task automatic send_set(input int n, input int mode, input bit may_idle);
		logic [VAL_W-1:0] v;
		for (int i = 0; i < n; i++) begin
			case (mode)
				VAL_FULL: v = VAL_W'($urandom_range(0, 499));
				VAL_NARROW: v = VAL_W'($urandom_range(0, 7));
				default: v = $urandom_range(0, 1) ? 9'd499 : 9'd0;
			endcase
			send_item(v, i == n - 1, may_idle);
		end
	endtask

	initial begin
		int n;
		int pick;
		int sent_rand;
		int set_no;
		bit quiet;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tlast <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes and duplicates
		send_item(9'd499, 1'b0, 1'b1);
		send_item(9'd0, 1'b0, 1'b1);
		send_item(9'd256, 1'b0, 1'b1);
		send_item(9'd255, 1'b0, 1'b1);
		send_item(9'd0, 1'b0, 1'b1);
		send_item(9'd499, 1'b0, 1'b1);
		send_item(9'd1, 1'b1, 1'b1);
		// single-item sets
		send_item(9'd0, 1'b1, 1'b1);
		send_item(9'd499, 1'b1, 1'b1);
		// descending
		send_item(9'd9, 1'b0, 1'b1);
		send_item(9'd8, 1'b0, 1'b1);
		send_item(9'd7, 1'b0, 1'b1);
		send_item(9'd6, 1'b0, 1'b1);
		send_item(9'd5, 1'b1, 1'b1);
		// all equal, order must be kept
		send_item(9'd3, 1'b0, 1'b1);
		send_item(9'd3, 1'b0, 1'b1);
		send_item(9'd3, 1'b0, 1'b1);
		send_item(9'd3, 1'b1, 1'b1);

		sent_rand = 0;
		set_no = 0;
		while (sent_rand < RAND_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (set_no == 3)
				n = SET_CAP + 2;
			else if (pick < 4)
				n = SET_CAP + $urandom_range(1, 4);
			else if (pick < 8)
				n = SET_CAP;
			else if (pick < 14)
				n = 1;
			else
				n = $urandom_range(2, 12);
			quiet = (sb.items_in >= 200 && sb.items_in < 270);
			send_set(n, $urandom_range(VAL_FULL, VAL_EXTREME), !quiet);
			sent_rand += n;
			set_no++;
		end
		s_tvalid <= 1'b0;

		while (sb.sorted_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("** pairwise_rank_sorter_unit: PASSED **");
		else
			$display("** pairwise_rank_sorter_unit: FAILED **");
		$finish;
	end

	// receiver: random stalls, one long hold-off, one stretch without stalls
	initial begin
		int hold_left;
		bit held_once;
		hold_left = 0;
		held_once = 1'b0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata, m_tlast);
			if (!held_once && sb.items_in >= 120) begin
				held_once = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (sb.results_out >= 150 && sb.results_out < 260) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	initial begin
		#2_000_000;
		$display("** pairwise_rank_sorter_unit: FAILED **");
		$finish;
	end
endmodule

@@ sim.f @@
design/prs_pkg.sv
design/prs_cell.sv
design/pairwise_rank_sorter_unit.sv
design/prs_checker.sv
sim/testbench.sv
